[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Both expect signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BSFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define BSFR_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[rtl/bsfr_pkg.sv]
`default_nettype none
package bsfr_pkg;

	localparam logic [7:0] PREAMBLE_BYTE = 8'h7E;
	localparam logic [7:0] ESCAPE_BYTE   = 8'h7D;
	localparam logic [7:0] ESCAPE_XOR    = 8'h20;

	localparam int HDR_BYTES = 3;
	localparam int PAY_DEPTH = 15;

	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic clr_frame;    // preamble seen
		logic set_esc;
		logic consume;      // unescaped byte taken
		logic sum_en;
		logic hdr_wr;
		logic pay_wr;
		logic trl_wr;
		logic idx_inc;
		logic idx_clr;
		logic ok_cap;       // second trailer byte: latch verdict
		logic load_status;
		logic load_payload;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic preamble;
		logic esc_start;
		logic hdr_done;
		logic len_zero;
		logic pay_done;
		logic trl_second;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

[rtl/bsfr_dp.sv]
`default_nettype none
module bsfr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic               cfg_write_data,
	input  logic [7:0]         rx_byte,
	input  logic               out_stall,
	input  bsfr_pkg::dp_cmd_t  cmd,
	output bsfr_pkg::dp_stat_t stat,
	output logic               out_valid,
	output logic               kind,
	output logic               checksum_ok,
	output logic [3:0]         pay_len,
	output logic [3:0]         frame_flags,
	output logic [7:0]         address_byte,
	output logic [7:0]         msg_code,
	output logic [7:0]         data_byte,
	output logic               last
);
	import bsfr_pkg::*;
	`include "assert_macros.svh"

	logic       cfg_en_q;
	logic       esc_q;
	logic [3:0] idx_q;
	logic [3:0] emit_idx_q;
	logic [7:0] sum_a_q;
	logic [7:0] sum_b_q;
	logic [7:0] hdr_q [HDR_BYTES];
	logic [7:0] pay_mem [PAY_DEPTH];
	logic [7:0] trl_q;
	logic [7:0] rd_q;
	logic       ok_q;
	logic       out_valid_q;

	logic [7:0] ubyte;
	logic [7:0] sum_a_d;
	logic [3:0] len;
	logic       ok;

	assign ubyte   = esc_q ? (rx_byte ^ ESCAPE_XOR) : rx_byte;
	assign sum_a_d = sum_a_q + ubyte;
	assign len     = hdr_q[0][7:4];
	assign ok      = !cfg_en_q || (trl_q == sum_a_q && ubyte == sum_b_q);

	always_comb begin
		stat.preamble   = (rx_byte == PREAMBLE_BYTE);
		stat.esc_start  = !esc_q && (rx_byte == ESCAPE_BYTE);
		stat.hdr_done   = (idx_q == 4'(HDR_BYTES - 1));
		stat.len_zero   = (len == 4'd0);
		stat.pay_done   = (({1'b0, idx_q} + 5'd1) == {1'b0, len});
		stat.trl_second = (idx_q != 4'd0);
		stat.emit_last  = (({1'b0, emit_idx_q} + 5'd1) == {1'b0, len});
		stat.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_en_q    <= 1'b1;
			esc_q       <= 1'b0;
			idx_q       <= '0;
			emit_idx_q  <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				cfg_en_q <= cfg_write_data;
			end
			if (cmd.clr_frame || cmd.consume) begin
				esc_q <= 1'b0;
			end else if (cmd.set_esc) begin
				esc_q <= 1'b1;
			end
			if (cmd.clr_frame || cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 4'd1;
			end
			if (cmd.clr_frame) begin
				sum_a_q <= '0;
				sum_b_q <= '0;
			end else if (cmd.sum_en) begin
				sum_a_q <= sum_a_d;
				sum_b_q <= sum_b_q + sum_a_d;
			end
			if (cmd.ok_cap) begin
				emit_idx_q <= '0;
			end else if (cmd.load_payload) begin
				emit_idx_q <= emit_idx_q + 4'd1;
			end
			if (cmd.load_status || cmd.load_payload) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// frame storage and result register: no reset needed
	always_ff @(posedge clk) begin
		if (cmd.hdr_wr) begin
			hdr_q[idx_q[1:0]] <= ubyte;
		end
		if (cmd.trl_wr) begin
			trl_q <= ubyte;
		end
		if (cmd.ok_cap) begin
			ok_q <= ok;
		end
		if (cmd.pay_wr) begin
			pay_mem[idx_q] <= ubyte;
		end
		rd_q <= pay_mem[emit_idx_q];
		if (cmd.load_status || cmd.load_payload) begin
			kind         <= cmd.load_payload ? KIND_PAYLOAD : KIND_STATUS;
			checksum_ok  <= ok_q;
			pay_len      <= len;
			frame_flags  <= hdr_q[0][3:0];
			address_byte <= hdr_q[1];
			msg_code     <= hdr_q[2];
			data_byte    <= cmd.load_payload ? rd_q : 8'd0;
			last         <= cmd.load_payload ? stat.emit_last : stat.len_zero;
		end
	end

	assign out_valid = out_valid_q;

	`BSFR_ASSERT(a_pay_wr_bound, cmd.pay_wr |-> ({1'b0, idx_q} < {1'b0, len}), "payload write past length")
	`BSFR_ASSERT(a_emit_bound, cmd.load_payload |-> ({1'b0, emit_idx_q} < {1'b0, len}), "payload read past length")
	`BSFR_NEVER(a_hdr_bound, cmd.hdr_wr && idx_q >= 4'(HDR_BYTES), "header index overrun")

endmodule
`default_nettype wire

[rtl/bsfr_ctrl.sv]
`default_nettype none
module bsfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bsfr_pkg::dp_stat_t stat,
	output bsfr_pkg::dp_cmd_t  cmd
);
	import bsfr_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [6:0] {
		ST_HUNT    = 7'b0000001,
		ST_HEADER  = 7'b0000010,
		ST_PAYLOAD = 7'b0000100,
		ST_TRAILER = 7'b0001000,
		ST_STATUS  = 7'b0010000,
		ST_PAY     = 7'b0100000,
		ST_FETCH   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   run;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		run     = 1'b0;
		unique case (state_q)
			ST_HUNT, ST_HEADER, ST_PAYLOAD, ST_TRAILER: begin
				run = 1'b1;
				if (in_valid) begin
					if (stat.preamble) begin
						cmd.clr_frame = 1'b1;
						state_d       = ST_HEADER;
					end else if (stat.esc_start) begin
						cmd.set_esc = 1'b1;
					end else begin
						cmd.consume = 1'b1;
						cmd.sum_en  = (state_q != ST_TRAILER);
						unique case (state_q)
							ST_HEADER: begin
								cmd.hdr_wr = 1'b1;
								if (stat.hdr_done) begin
									cmd.idx_clr = 1'b1;
									state_d     = stat.len_zero ? ST_TRAILER : ST_PAYLOAD;
								end else begin
									cmd.idx_inc = 1'b1;
								end
							end
							ST_PAYLOAD: begin
								cmd.pay_wr = 1'b1;
								if (stat.pay_done) begin
									cmd.idx_clr = 1'b1;
									state_d     = ST_TRAILER;
								end else begin
									cmd.idx_inc = 1'b1;
								end
							end
							ST_TRAILER: begin
								if (stat.trl_second) begin
									cmd.ok_cap  = 1'b1;
									cmd.idx_clr = 1'b1;
									state_d     = ST_STATUS;
								end else begin
									cmd.trl_wr  = 1'b1;
									cmd.idx_inc = 1'b1;
								end
							end
							default: begin
								// hunting: byte only feeds the sums
							end
						endcase
					end
				end
			end
			ST_STATUS: begin
				if (stat.out_free) begin
					cmd.load_status = 1'b1;
					state_d         = stat.len_zero ? ST_HUNT : ST_PAY;
				end
			end
			ST_PAY: begin
				if (stat.out_free) begin
					cmd.load_payload = 1'b1;
					state_d          = stat.emit_last ? ST_HUNT : ST_FETCH;
				end
			end
			ST_FETCH: begin
				// store read is registered: wait here while the next byte is read
				state_d = ST_PAY;
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = !run;

	`BSFR_ASSERT(a_load_when_free, (cmd.load_status || cmd.load_payload) |-> stat.out_free, "result loaded over a waiting beat")
	`BSFR_ASSERT(a_frame_end_status, cmd.ok_cap |=> (state_q == ST_STATUS), "frame end did not start status")
	`BSFR_NEVER(a_no_byte_in_burst, (cmd.consume || cmd.clr_frame) && !run, "input byte taken during result burst")

endmodule
`default_nettype wire

[rtl/byte_stuffed_frame_receiver_top.sv]
`default_nettype none
// Byte-stuffed frame receiver. Raw line bytes come in on rx_byte; 0x7E restarts
// a frame, 0x7D escapes the next byte (XOR 0x20). A frame is three header bytes,
// up to 15 payload bytes and two Fletcher-style checksum bytes. Each raw byte is
// taken in one cycle. On the second checksum byte the input stalls while the
// result burst is built: one status beat (header fields and verdict), then one
// beat per payload byte, the final beat flagged by last. Every payload beat after
// the first waits in a fetch state for the registered read of the payload store.
// A result still waiting on the output does not stop new line bytes once the
// burst is done. checksum_enable resets to 1 and is written through
// cfg_write_en/cfg_write_data; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module byte_stuffed_frame_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic       cfg_write_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic       checksum_ok,
	output logic [3:0] pay_len,
	output logic [3:0] frame_flags,
	output logic [7:0] address_byte,
	output logic [7:0] msg_code,
	output logic [7:0] data_byte,
	output logic       last
);
	import bsfr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bsfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bsfr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.rx_byte        (rx_byte),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.kind           (kind),
		.checksum_ok    (checksum_ok),
		.pay_len        (pay_len),
		.frame_flags    (frame_flags),
		.address_byte   (address_byte),
		.msg_code       (msg_code),
		.data_byte      (data_byte),
		.last           (last)
	);

endmodule
`default_nettype wire
